/* rtl/scm_pkg.sv */
// ============================================================================
// scm_pkg
// Shared types, codes and constants of the stepper cross-fade microstep block.
// ============================================================================
package scm_pkg;

   // Field widths of the channels and the configuration port.
   localparam int CMD_BITS        = 2;
   localparam int PHASE_BITS      = 2;
   localparam int COIL_BITS       = 4;
   localparam int LEVEL_PORT_BITS = 16;
   localparam int CFG_TOP_BITS    = 16;
   localparam int CFG_MSTEP_BITS  = 11;
   localparam int CFG_TIME_BITS   = 10;
   localparam int CSR_INDEX_BITS  = 2;
   localparam int CSR_DATA_BITS   = 16;

   // Defaults of the top-level parameters.
   localparam int DEF_LEVEL_BITS = 16;
   localparam int DEF_TICK_BITS  = 20;

   // Shared divider: the dividend holds the step duration in milliseconds
   // times 1000 at most.
   localparam int DVD_BITS     = 20;
   localparam int DVS_BITS     = CFG_MSTEP_BITS;
   localparam int DIV_CNT_BITS = $clog2(DVD_BITS + 1);
   localparam int US_PER_MS    = 1000;

   // Reset values of the configuration registers.
   localparam logic [CFG_TOP_BITS-1:0]   TOP_RESET   = CFG_TOP_BITS'(1000);
   localparam logic [CFG_MSTEP_BITS-1:0] MSTEP_RESET = CFG_MSTEP_BITS'(10);
   localparam logic [CFG_TIME_BITS-1:0]  TIME_RESET  = CFG_TIME_BITS'(10);

   // Command codes.
   localparam logic [CMD_BITS-1:0] CMD_TICK   = 2'd0;
   localparam logic [CMD_BITS-1:0] CMD_SMOOTH = 2'd1;
   localparam logic [CMD_BITS-1:0] CMD_FULL   = 2'd2;

   // Configuration register indexes.
   localparam logic [CSR_INDEX_BITS-1:0] CSR_PWM_TOP    = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_MICROSTEPS = 2'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_STEP_TIME  = 2'd2;

   typedef struct packed {
      logic                    start;
      logic [DIV_CNT_BITS-1:0] iters;
      logic [DVD_BITS-1:0]     dividend;
      logic [DVS_BITS-1:0]     divisor;
   } div_req_type;

   typedef struct packed {
      logic                done;
      logic [DVD_BITS-1:0] quotient;
   } div_rsp_type;

   typedef struct packed {
      logic                       accepted;
      logic                       busy_res;
      logic [PHASE_BITS-1:0]      phase;
      logic [COIL_BITS-1:0]       coils;
      logic [LEVEL_PORT_BITS-1:0] level_a;
      logic [LEVEL_PORT_BITS-1:0] level_b;
      logic                       pwm_enabled;
      logic                       ramp_done;
   } rsp_payload_type;

   // Coil lines per phase, ordered A+, A-, B+, B- from the top bit down.
   function automatic logic [COIL_BITS-1:0] coil_pattern(input logic [PHASE_BITS-1:0] ph);
      logic [COIL_BITS-1:0] pat;
      unique case (ph)
         2'd0:    pat = 4'b1001;
         2'd1:    pat = 4'b1010;
         2'd2:    pat = 4'b0110;
         default: pat = 4'b0101;
      endcase
      return pat;
   endfunction

endpackage

/* rtl/scm_if.sv */
// ============================================================================
// scm_if
// Request and response channel interfaces with valid/ready handshakes.
// ============================================================================
interface scm_req_if import scm_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [CMD_BITS-1:0] command;
   logic                direction;

   modport source (output valid, output command, output direction, input ready);
   modport sink   (input valid, input command, input direction, output ready);
endinterface

interface scm_rsp_if import scm_pkg::*; ();
   logic                       valid;
   logic                       ready;
   logic                       accepted;
   logic                       busy_res;
   logic [PHASE_BITS-1:0]      phase;
   logic                       coil_a_pos;
   logic                       coil_a_neg;
   logic                       coil_b_pos;
   logic                       coil_b_neg;
   logic [LEVEL_PORT_BITS-1:0] level_a;
   logic [LEVEL_PORT_BITS-1:0] level_b;
   logic                       pwm_enabled;
   logic                       ramp_done;

   modport source (output valid, output accepted, output busy_res, output phase,
                   output coil_a_pos, output coil_a_neg, output coil_b_pos,
                   output coil_b_neg, output level_a, output level_b,
                   output pwm_enabled, output ramp_done, input ready);
   modport sink   (input valid, input accepted, input busy_res, input phase,
                   input coil_a_pos, input coil_a_neg, input coil_b_pos,
                   input coil_b_neg, input level_a, input level_b,
                   input pwm_enabled, input ramp_done, output ready);
endinterface

/* rtl/scm_divider.sv */
// ============================================================================
// scm_divider
// Restoring divider, one quotient bit per cycle, shared by both per-step
// divisions.
// ============================================================================
module scm_divider import scm_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  div_req_type div_req,
   output div_rsp_type div_rsp
);

   logic                    busy_ff, busy_in;
   logic                    done_ff, done_in;
   logic [DIV_CNT_BITS-1:0] cnt_ff, cnt_in;
   logic [DVS_BITS-1:0]     rem_ff, rem_in;
   logic [DVD_BITS-1:0]     quo_ff, quo_in;
   logic [DVS_BITS-1:0]     dvs_ff, dvs_in;

   logic [DVS_BITS:0] trial;
   logic [DVS_BITS:0] diff;
   logic              fits;

   // The dividend shifts out of the top of quo_ff while quotient bits enter
   // at the bottom.
   assign trial = {rem_ff, quo_ff[DVD_BITS-1]};
   assign fits  = trial >= {1'b0, dvs_ff};
   assign diff  = trial - {1'b0, dvs_ff};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dvs_in  = dvs_ff;
      if (div_req.start) begin
         busy_in = 1'b1;
         cnt_in  = div_req.iters;
         rem_in  = '0;
         quo_in  = div_req.dividend;
         dvs_in  = div_req.divisor;
      end else if (busy_ff) begin
         rem_in = fits ? diff[DVS_BITS-1:0] : trial[DVS_BITS-1:0];
         quo_in = {quo_ff[DVD_BITS-2:0], fits};
         cnt_in = cnt_ff - DIV_CNT_BITS'(1);
         if (cnt_ff == DIV_CNT_BITS'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff <= cnt_in;
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dvs_ff <= dvs_in;
   end

   assign div_rsp.done     = done_ff;
   assign div_rsp.quotient = quo_ff;

endmodule

/* rtl/stepper_crossfade_microstep.sv */
// ============================================================================
// stepper_crossfade_microstep
// Two-phase stepper drive with full steps and linear PWM cross-fade ramps.
// A tick, full step or ignored command passes the execute and finish states
// before its beat is registered; a smooth step that starts a ramp also waits
// in between on two passes through the shared bit-serial divider.
// One command is taken at a time; ready is low while working or stalled.
// Reset: synchronous; coils off, ramp level at zero, registers at their defaults.
// ============================================================================
module stepper_crossfade_microstep import scm_pkg::*; #(
   parameter int LEVEL_BITS = DEF_LEVEL_BITS,
   parameter int TICK_BITS  = DEF_TICK_BITS
) (
   input  logic                      clock,
   input  logic                      reset,
   scm_req_if.sink                   req_chan,
   scm_rsp_if.source                 rsp_chan,
   input  logic                      csr_we,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [CSR_DATA_BITS-1:0]  csr_wdata
);

   typedef enum logic [4:0] {
      ST_IDLE    = 5'b00001,
      ST_EXEC    = 5'b00010,
      ST_DIV_TOP = 5'b00100,
      ST_DIV_PER = 5'b01000,
      ST_FINISH  = 5'b10000
   } state_type;

   localparam logic [LEVEL_BITS-1:0] LVL_MAX   = '1;
   localparam logic [TICK_BITS-1:0]  TICK_MAX  = '1;
   localparam int                    WIDE_BITS = (TICK_BITS > DVD_BITS) ? TICK_BITS : DVD_BITS;

   // Configuration registers.
   logic [CFG_TOP_BITS-1:0]   pwm_top_ff, pwm_top_in;
   logic [CFG_MSTEP_BITS-1:0] mstep_ff, mstep_in;
   logic [CFG_TIME_BITS-1:0]  step_time_ff, step_time_in;

   // Sequencer and drive state.
   state_type             state_ff, state_in;
   logic [CMD_BITS-1:0]   cmd_ff, cmd_in;
   logic                  dir_ff, dir_in;
   logic [PHASE_BITS-1:0] phase_ff, phase_in;
   logic [LEVEL_BITS-1:0] level_ff, level_in;
   logic                  rising_ff, rising_in;
   logic [LEVEL_BITS-1:0] step_ff, step_in;
   logic [TICK_BITS-1:0]  period_ff, period_in;
   logic [TICK_BITS-1:0]  count_ff, count_in;
   logic                  busy_ff, busy_in;
   logic                  pwm_ff, pwm_in;
   logic [COIL_BITS-1:0]  coil_ff, coil_in;
   logic                  full_ff, full_in;
   logic                  accepted_ff, accepted_in;
   logic                  done_ff, done_in;
   logic [DVD_BITS-1:0]   prod_ff, prod_in;

   // Output register.
   rsp_payload_type rsp_ff, rsp_in;
   logic            rsp_valid_ff, rsp_valid_in;
   logic            rsp_load;

   div_req_type div_req;
   div_rsp_type div_rsp;

   logic [LEVEL_BITS-1:0]   top_lvl;
   logic [DVS_BITS-1:0]     mstep_eff;
   logic [LEVEL_BITS:0]     ramp_sum;
   logic                    rise_over;
   logic                    fall_under;
   logic [TICK_BITS:0]      count_inc;
   logic [PHASE_BITS-1:0]   phase_adv;
   logic [WIDE_BITS-1:0]    quo_wide;
   logic [LEVEL_BITS-1:0]   level_b_val;

   // Full scale saturates at what the level registers can hold.
   assign top_lvl   = (pwm_top_ff > CFG_TOP_BITS'(LVL_MAX)) ? LVL_MAX
                                                            : pwm_top_ff[LEVEL_BITS-1:0];
   assign mstep_eff = (mstep_ff == '0) ? DVS_BITS'(1) : mstep_ff;

   assign ramp_sum   = {1'b0, level_ff} + {1'b0, step_ff};
   assign rise_over  = ramp_sum > {1'b0, top_lvl};
   assign fall_under = step_ff > level_ff;
   assign count_inc  = (TICK_BITS+1)'(count_ff) + (TICK_BITS+1)'(1);
   assign phase_adv  = dir_ff ? (phase_ff - PHASE_BITS'(1)) : (phase_ff + PHASE_BITS'(1));
   assign quo_wide   = WIDE_BITS'(div_rsp.quotient);

   always_comb begin
      pwm_top_in   = pwm_top_ff;
      mstep_in     = mstep_ff;
      step_time_in = step_time_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_PWM_TOP:    pwm_top_in   = csr_wdata;
            CSR_MICROSTEPS: mstep_in     = csr_wdata[CFG_MSTEP_BITS-1:0];
            CSR_STEP_TIME:  step_time_in = csr_wdata[CFG_TIME_BITS-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      state_in    = state_ff;
      cmd_in      = cmd_ff;
      dir_in      = dir_ff;
      phase_in    = phase_ff;
      level_in    = level_ff;
      rising_in   = rising_ff;
      step_in     = step_ff;
      period_in   = period_ff;
      count_in    = count_ff;
      busy_in     = busy_ff;
      pwm_in      = pwm_ff;
      coil_in     = coil_ff;
      full_in     = full_ff;
      accepted_in = accepted_ff;
      done_in     = done_ff;
      prod_in     = prod_ff;
      rsp_load    = 1'b0;

      div_req.start    = 1'b0;
      div_req.iters    = DIV_CNT_BITS'(LEVEL_BITS);
      div_req.dividend = DVD_BITS'(top_lvl) << (DVD_BITS - LEVEL_BITS);
      div_req.divisor  = mstep_eff;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_chan.valid) begin
               cmd_in      = req_chan.command;
               dir_in      = req_chan.direction;
               accepted_in = 1'b0;
               done_in     = 1'b0;
               state_in    = ST_EXEC;
            end
         end
         ST_EXEC: begin
            state_in = ST_FINISH;
            unique case (cmd_ff)
               CMD_TICK: begin
                  if (busy_ff) begin
                     if (count_inc >= (TICK_BITS+1)'(period_ff)) begin
                        count_in = '0;
                        full_in  = 1'b0;
                        if (rising_ff) begin
                           level_in = rise_over ? top_lvl : ramp_sum[LEVEL_BITS-1:0];
                           done_in  = rise_over;
                        end else begin
                           level_in = fall_under ? '0 : (level_ff - step_ff);
                           done_in  = fall_under;
                        end
                        if ((rising_ff && rise_over) || (!rising_ff && fall_under)) begin
                           busy_in = 1'b0;
                           pwm_in  = 1'b0;
                        end
                     end else begin
                        count_in = count_inc[TICK_BITS-1:0];
                     end
                  end
               end
               CMD_SMOOTH: begin
                  if (!busy_ff) begin
                     accepted_in   = 1'b1;
                     busy_in       = 1'b1;
                     pwm_in        = 1'b1;
                     full_in       = 1'b0;
                     coil_in       = coil_pattern(phase_ff);
                     rising_in     = !phase_ff[0];
                     level_in      = phase_ff[0] ? top_lvl : '0;
                     count_in      = '0;
                     phase_in      = phase_adv;
                     prod_in       = DVD_BITS'(step_time_ff) * DVD_BITS'(US_PER_MS);
                     div_req.start = 1'b1;
                     state_in      = ST_DIV_TOP;
                  end
               end
               CMD_FULL: begin
                  accepted_in = 1'b1;
                  coil_in     = coil_pattern(phase_ff);
                  full_in     = 1'b1;
                  phase_in    = phase_adv;
               end
               default: ;
            endcase
         end
         ST_DIV_TOP: begin
            if (div_rsp.done) begin
               step_in = (div_rsp.quotient == '0) ? LEVEL_BITS'(1)
                                                  : div_rsp.quotient[LEVEL_BITS-1:0];
               div_req.start    = 1'b1;
               div_req.iters    = DIV_CNT_BITS'(DVD_BITS);
               div_req.dividend = prod_ff;
               state_in         = ST_DIV_PER;
            end
         end
         ST_DIV_PER: begin
            if (div_rsp.done) begin
               if (quo_wide == '0) begin
                  period_in = TICK_BITS'(1);
               end else if (quo_wide > WIDE_BITS'(TICK_MAX)) begin
                  period_in = TICK_MAX;
               end else begin
                  period_in = quo_wide[TICK_BITS-1:0];
               end
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (!rsp_valid_ff || rsp_chan.ready) begin
               rsp_load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   assign level_b_val = (top_lvl > level_ff) ? (top_lvl - level_ff) : '0;

   always_comb begin
      rsp_in             = rsp_ff;
      rsp_in.accepted    = accepted_ff;
      rsp_in.busy_res    = busy_ff;
      rsp_in.phase       = phase_ff;
      rsp_in.coils       = coil_ff;
      rsp_in.level_a     = LEVEL_PORT_BITS'(full_ff ? top_lvl : level_ff);
      rsp_in.level_b     = LEVEL_PORT_BITS'(full_ff ? top_lvl : level_b_val);
      rsp_in.pwm_enabled = pwm_ff;
      rsp_in.ramp_done   = done_ff;
      if (!rsp_load) begin
         rsp_in = rsp_ff;
      end
   end

   assign rsp_valid_in = rsp_load || (rsp_valid_ff && !rsp_chan.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         pwm_top_ff   <= TOP_RESET;
         mstep_ff     <= MSTEP_RESET;
         step_time_ff <= TIME_RESET;
         state_ff     <= ST_IDLE;
         phase_ff     <= '0;
         level_ff     <= '0;
         rising_ff    <= 1'b0;
         step_ff      <= LEVEL_BITS'(1);
         period_ff    <= TICK_BITS'(1);
         count_ff     <= '0;
         busy_ff      <= 1'b0;
         pwm_ff       <= 1'b0;
         coil_ff      <= '0;
         full_ff      <= 1'b0;
         accepted_ff  <= 1'b0;
         done_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         pwm_top_ff   <= pwm_top_in;
         mstep_ff     <= mstep_in;
         step_time_ff <= step_time_in;
         state_ff     <= state_in;
         phase_ff     <= phase_in;
         level_ff     <= level_in;
         rising_ff    <= rising_in;
         step_ff      <= step_in;
         period_ff    <= period_in;
         count_ff     <= count_in;
         busy_ff      <= busy_in;
         pwm_ff       <= pwm_in;
         coil_ff      <= coil_in;
         full_ff      <= full_in;
         accepted_ff  <= accepted_in;
         done_ff      <= done_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff  <= cmd_in;
      dir_ff  <= dir_in;
      prod_ff <= prod_in;
      rsp_ff  <= rsp_in;
   end

   scm_divider u_divider (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   assign req_chan.ready       = (state_ff == ST_IDLE);
   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.accepted    = rsp_ff.accepted;
   assign rsp_chan.busy_res    = rsp_ff.busy_res;
   assign rsp_chan.phase       = rsp_ff.phase;
   assign rsp_chan.coil_a_pos  = rsp_ff.coils[3];
   assign rsp_chan.coil_a_neg  = rsp_ff.coils[2];
   assign rsp_chan.coil_b_pos  = rsp_ff.coils[1];
   assign rsp_chan.coil_b_neg  = rsp_ff.coils[0];
   assign rsp_chan.level_a     = rsp_ff.level_a;
   assign rsp_chan.level_b     = rsp_ff.level_b;
   assign rsp_chan.pwm_enabled = rsp_ff.pwm_enabled;
   assign rsp_chan.ramp_done   = rsp_ff.ramp_done;

endmodule

/* rtl/scm_checker.sv */
// ============================================================================
// scm_checker
// Port-level checks of the stepper cross-fade microstep block.
// ============================================================================
module scm_checker (
   input logic clock,
   input logic reset,
   input logic req_valid,
   input logic req_ready,
   input logic rsp_valid,
   input logic rsp_ready,
   input logic rsp_busy_res,
   input logic rsp_pwm_enabled,
   input logic rsp_ramp_done,
   input logic rsp_coil_a_pos,
   input logic rsp_coil_a_neg,
   input logic rsp_coil_b_pos,
   input logic rsp_coil_b_neg
);

   // No result beat may be pending right after reset.
   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result beat valid after reset");

   // A stalled result beat stays offered.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result beat dropped while stalled");

   // The block works on one beat at a time.
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request taken while a beat is in progress");

   // A coil is never driven both ways at once.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_coil_a_pos && rsp_coil_a_neg) && !(rsp_coil_b_pos && rsp_coil_b_neg))
      else $error("coil driven in both directions");

   // A finished ramp leaves the drive idle with PWM off.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ramp_done |-> !rsp_busy_res && !rsp_pwm_enabled)
      else $error("ramp finished but drive still busy");

endmodule

bind stepper_crossfade_microstep scm_checker u_scm_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_chan.valid),
   .req_ready       (req_chan.ready),
   .rsp_valid       (rsp_chan.valid),
   .rsp_ready       (rsp_chan.ready),
   .rsp_busy_res    (rsp_chan.busy_res),
   .rsp_pwm_enabled (rsp_chan.pwm_enabled),
   .rsp_ramp_done   (rsp_chan.ramp_done),
   .rsp_coil_a_pos  (rsp_chan.coil_a_pos),
   .rsp_coil_a_neg  (rsp_chan.coil_a_neg),
   .rsp_coil_b_pos  (rsp_chan.coil_b_pos),
   .rsp_coil_b_neg  (rsp_chan.coil_b_neg)
);

/* test/tb_stepper_crossfade_microstep.sv */
// ============================================================================
// tb_stepper_crossfade_microstep
// Self-checking testbench for the stepper cross-fade microstep drive.
// A directed table covers reset outputs, every command, the phase table
// in both directions, extreme register values and ramp clamping. Random
// phases then reprogram the registers and run full steps, smooth-step ramps
// and ticks. Every response beat is checked against its table entry or a drive
// predictor kept inside the testbench. Both channel sides stall at random.
// ============================================================================
module tb_stepper_crossfade_microstep;
   import scm_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int LEVEL_W        = DEF_LEVEL_BITS;
   localparam int TICK_W         = DEF_TICK_BITS;
   localparam int unsigned LEVEL_MAX      = (1 << LEVEL_W) - 1;
   localparam longint unsigned TICK_MAX   = (64'd1 << TICK_W) - 1;
   localparam int ITEM_TARGET    = 600;
   localparam int RAMP_TICK_CAP  = 400;
   localparam int SETTLE_CYCLES  = 6;
   localparam int TAIL_CYCLES    = 60;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int REPORT_LIMIT   = 10;
   localparam int PLAN_ROWS      = 25;

   localparam logic [CMD_BITS-1:0]       CMD_UNUSED = 2'd3;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_UNUSED = 2'd3;

   localparam logic [COIL_BITS-1:0] COIL_BY_PHASE [4] = '{4'b1001, 4'b1010, 4'b0110, 4'b0101};

   typedef enum bit {ROW_BEAT, ROW_CSR} row_kind_type;

   typedef struct packed {
      row_kind_type               kind;
      logic [CMD_BITS-1:0]        cmd;
      logic                       dir;
      logic [CSR_INDEX_BITS-1:0]  idx;
      logic [CSR_DATA_BITS-1:0]   data;
      logic                       typed;
      rsp_payload_type            want;
   } plan_row_type;

   localparam rsp_payload_type NO_WANT = '0;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                      req_valid     = 1'b0;
   logic [CMD_BITS-1:0]       req_command   = CMD_TICK;
   logic                      req_direction = 1'b0;
   logic                      rsp_ready_q   = 1'b0;
   logic                      csr_we        = 1'b0;
   logic [CSR_INDEX_BITS-1:0] csr_index     = CSR_PWM_TOP;
   logic [CSR_DATA_BITS-1:0]  csr_wdata     = '0;

   scm_req_if req_if ();
   scm_rsp_if rsp_if ();

   assign req_if.valid     = req_valid;
   assign req_if.command   = req_command;
   assign req_if.direction = req_direction;
   assign rsp_if.ready     = rsp_ready_q;

   stepper_crossfade_microstep u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_if),
      .rsp_chan  (rsp_if),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always #1 clock = ~clock;

   // Predictor copy of the registers and the drive state.
   logic [CFG_TOP_BITS-1:0]   cfg_top    = TOP_RESET;
   logic [CFG_MSTEP_BITS-1:0] cfg_msteps = MSTEP_RESET;
   logic [CFG_TIME_BITS-1:0]  cfg_time   = TIME_RESET;

   logic [PHASE_BITS-1:0] st_phase  = '0;
   logic [LEVEL_W-1:0]    st_level  = '0;
   logic                  st_rising = 1'b0;
   logic [LEVEL_W-1:0]    st_step   = LEVEL_W'(1);
   logic [TICK_W-1:0]     st_period = TICK_W'(1);
   logic [TICK_W-1:0]     st_count  = '0;
   logic                  st_busy   = 1'b0;
   logic                  st_pwm    = 1'b0;
   logic                  st_full   = 1'b0;
   logic [COIL_BITS-1:0]  st_coils  = '0;

   rsp_payload_type drive_due [$];
   int  fault_count = 0;
   int  idle_cycles = 0;
   bit  calm        = 1'b0;
   int unsigned stall_left = 0;

   function automatic int unsigned level_top();
      return (cfg_top > LEVEL_MAX) ? LEVEL_MAX : cfg_top;
   endfunction

   // Number of ticks the ramp started by a smooth step would take right now.
   function automatic longint unsigned ramp_length();
      longint unsigned top, m, stp, per;
      top = level_top();
      m   = (cfg_msteps == 0) ? 1 : cfg_msteps;
      stp = top / m;
      if (stp == 0) stp = 1;
      per = (longint'(cfg_time) * US_PER_MS) / m;
      if (per == 0) per = 1;
      return per * (top / stp + 2);
   endfunction

   function automatic rsp_payload_type predict_drive(input logic [CMD_BITS-1:0] cmd,
                                                     input logic dir);
      rsp_payload_type r;
      int unsigned     top, msteps, nxt;
      longint unsigned per;
      logic            acc, done;
      acc = 1'b0;
      done = 1'b0;
      top = level_top();
      case (cmd)
         CMD_TICK: begin
            if (st_busy) begin
               st_count = st_count + TICK_W'(1);
               if (st_count >= st_period) begin
                  st_count = '0;
                  st_full  = 1'b0;
                  if (st_rising) begin
                     nxt = st_level + st_step;
                     if (nxt > top) begin
                        nxt = top;
                        done = 1'b1;
                     end
                     st_level = LEVEL_W'(nxt);
                  end else if (st_step > st_level) begin
                     st_level = '0;
                     done = 1'b1;
                  end else begin
                     st_level = st_level - st_step;
                  end
                  if (done) begin
                     st_busy = 1'b0;
                     st_pwm  = 1'b0;
                  end
               end
            end
         end
         CMD_SMOOTH: begin
            if (!st_busy) begin
               msteps   = (cfg_msteps == 0) ? 1 : cfg_msteps;
               acc      = 1'b1;
               st_busy  = 1'b1;
               st_pwm   = 1'b1;
               st_full  = 1'b0;
               st_coils = COIL_BY_PHASE[st_phase];
               // Even phases ramp A up from zero, odd phases ramp it down from top.
               if (!st_phase[0]) begin
                  st_level  = '0;
                  st_rising = 1'b1;
               end else begin
                  st_level  = LEVEL_W'(top);
                  st_rising = 1'b0;
               end
               st_step = LEVEL_W'(top / msteps);
               if (st_step == 0) st_step = LEVEL_W'(1);
               per = (longint'(cfg_time) * US_PER_MS) / msteps;
               if (per == 0) per = 1;
               if (per > TICK_MAX) per = TICK_MAX;
               st_period = TICK_W'(per);
               st_count  = '0;
               st_phase  = dir ? st_phase - PHASE_BITS'(1) : st_phase + PHASE_BITS'(1);
            end
         end
         CMD_FULL: begin
            acc      = 1'b1;
            st_coils = COIL_BY_PHASE[st_phase];
            st_full  = 1'b1;
            st_phase = dir ? st_phase - PHASE_BITS'(1) : st_phase + PHASE_BITS'(1);
         end
         default: ;
      endcase
      r.accepted    = acc;
      r.busy_res    = st_busy;
      r.phase       = st_phase;
      r.coils       = st_coils;
      if (st_full) begin
         r.level_a = LEVEL_PORT_BITS'(top);
         r.level_b = LEVEL_PORT_BITS'(top);
      end else begin
         r.level_a = LEVEL_PORT_BITS'(st_level);
         r.level_b = (top > st_level) ? LEVEL_PORT_BITS'(top - st_level) : '0;
      end
      r.pwm_enabled = st_pwm;
      r.ramp_done   = done;
      return r;
   endfunction

   task automatic send_beat(input logic [CMD_BITS-1:0] cmd, input logic dir,
                            input logic typed, input rsp_payload_type want);
      int unsigned     gap;
      rsp_payload_type pred;
      gap = calm ? 0 : $urandom_range(0, 7);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_command   <= cmd;
      req_direction <= dir;
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
      pred = predict_drive(cmd, dir);
      drive_due.push_back(typed ? want : pred);
   endtask

   // Stop sending and wait until every expected beat has come back.
   task automatic drain();
      req_valid <= 1'b0;
      while (drive_due.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_INDEX_BITS-1:0] idx,
                            input logic [CSR_DATA_BITS-1:0] data);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      case (idx)
         CSR_PWM_TOP:    cfg_top    = data[CFG_TOP_BITS-1:0];
         CSR_MICROSTEPS: cfg_msteps = data[CFG_MSTEP_BITS-1:0];
         CSR_STEP_TIME:  cfg_time   = data[CFG_TIME_BITS-1:0];
         default: ;
      endcase
   endtask

   always @(posedge clock) begin
      if ((req_valid && req_if.ready) || (rsp_if.valid && rsp_ready_q))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
   end

   // Response side: check each beat, then draw the stall before the next one.
   always @(posedge clock) begin : rsp_side
      rsp_payload_type got, want;
      int unsigned     w;
      if (reset) begin
         rsp_ready_q <= 1'b0;
         stall_left  <= 0;
      end else if (rsp_if.valid && rsp_ready_q) begin
         got = {rsp_if.accepted, rsp_if.busy_res, rsp_if.phase, rsp_if.coil_a_pos,
                rsp_if.coil_a_neg, rsp_if.coil_b_pos, rsp_if.coil_b_neg, rsp_if.level_a,
                rsp_if.level_b, rsp_if.pwm_enabled, rsp_if.ramp_done};
         if (drive_due.size() == 0) begin
            if (fault_count < REPORT_LIMIT)
               $display("unexpected drive beat: acc=%0d busy=%0d phase=%0d coils=%b a=%0d b=%0d",
                        got.accepted, got.busy_res, got.phase, got.coils, got.level_a,
                        got.level_b);
            fault_count <= fault_count + 1;
         end else begin
            want = drive_due.pop_front();
            if (got.accepted !== want.accepted || got.busy_res !== want.busy_res ||
                got.phase !== want.phase || got.coils !== want.coils ||
                got.level_a !== want.level_a || got.level_b !== want.level_b ||
                got.pwm_enabled !== want.pwm_enabled || got.ramp_done !== want.ramp_done) begin
               if (fault_count < REPORT_LIMIT) begin
                  $display("drive beat mismatch, expected: acc=%0d busy=%0d phase=%0d coils=%b",
                           want.accepted, want.busy_res, want.phase, want.coils,
                           " a=%0d b=%0d pwm=%0d done=%0d", want.level_a, want.level_b,
                           want.pwm_enabled, want.ramp_done);
                  $display("                    actual:   acc=%0d busy=%0d phase=%0d coils=%b",
                           got.accepted, got.busy_res, got.phase, got.coils,
                           " a=%0d b=%0d pwm=%0d done=%0d", got.level_a, got.level_b,
                           got.pwm_enabled, got.ramp_done);
               end
               fault_count <= fault_count + 1;
            end
         end
         w = calm ? 0 : $urandom_range(0, 7);
         if (w == 0) begin
            rsp_ready_q <= 1'b1;
         end else begin
            rsp_ready_q <= 1'b0;
            stall_left  <= w;
         end
      end else if (stall_left > 1) begin
         stall_left <= stall_left - 1;
      end else if (stall_left == 1) begin
         stall_left  <= 0;
         rsp_ready_q <= 1'b1;
      end else begin
         rsp_ready_q <= 1'b1;
      end
   end

   initial begin : watchdog
      wait (idle_cycles >= WATCHDOG_LIMIT);
      $display("TB_ERROR");
      $finish;
   end

   initial begin : stimulus
      plan_row_type directed_plan [PLAN_ROWS];
      int unsigned TOP_EDGES [3];
      int unsigned MSTEP_EDGES [4];
      int unsigned TIME_EDGES [4];
      int          steps_counted;
      int unsigned roll, len, top_v, mstep_v, time_v;
      logic [CMD_BITS-1:0]      cmd;
      logic                     dir;
      logic                     last;
      logic [CSR_DATA_BITS-1:0] data;

      TOP_EDGES   = '{0, 1, 65535};
      MSTEP_EDGES = '{0, 1, 1024, 2047};
      TIME_EDGES  = '{0, 1, 1000, 1023};

      directed_plan = '{
         // Reset outputs, then an ignored command that must show them unchanged.
         '{ROW_BEAT, CMD_TICK, 1'b0, CSR_PWM_TOP, 16'd0, 1'b1,
           rsp_payload_type'{1'b0, 1'b0, 2'd0, 4'b0000, 16'd0, 16'd1000, 1'b0, 1'b0}},
         '{ROW_BEAT, CMD_UNUSED, 1'b1, CSR_PWM_TOP, 16'd0, 1'b1,
           rsp_payload_type'{1'b0, 1'b0, 2'd0, 4'b0000, 16'd0, 16'd1000, 1'b0, 1'b0}},
         '{ROW_BEAT, CMD_FULL, 1'b0, CSR_PWM_TOP, 16'd0, 1'b1,
           rsp_payload_type'{1'b1, 1'b0, 2'd1, 4'b1001, 16'd1000, 16'd1000, 1'b0, 1'b0}},
         '{ROW_BEAT, CMD_FULL, 1'b1, CSR_PWM_TOP, 16'd0, 1'b1,
           rsp_payload_type'{1'b1, 1'b0, 2'd0, 4'b1010, 16'd1000, 16'd1000, 1'b0, 1'b0}},
         '{ROW_BEAT, CMD_FULL, 1'b1, CSR_PWM_TOP, 16'd0, 1'b1,
           rsp_payload_type'{1'b1, 1'b0, 2'd3, 4'b1001, 16'd1000, 16'd1000, 1'b0, 1'b0}},
         '{ROW_CSR, CMD_TICK, 1'b0, CSR_PWM_TOP, 16'd65535, 1'b0, NO_WANT},
         '{ROW_BEAT, CMD_FULL, 1'b0, CSR_PWM_TOP, 16'd0, 1'b1,
           rsp_payload_type'{1'b1, 1'b0, 2'd0, 4'b0101, 16'd65535, 16'd65535, 1'b0, 1'b0}},
         // Zero microsteps and zero step time: one full-scale increment per tick.
         '{ROW_CSR, CMD_TICK, 1'b0, CSR_MICROSTEPS, 16'd0, 1'b0, NO_WANT},
         '{ROW_CSR, CMD_TICK, 1'b0, CSR_STEP_TIME, 16'd0, 1'b0, NO_WANT},
         '{ROW_BEAT, CMD_SMOOTH, 1'b0, CSR_PWM_TOP, 16'd0, 1'b1,
           rsp_payload_type'{1'b1, 1'b1, 2'd1, 4'b1001, 16'd0, 16'd65535, 1'b1, 1'b0}},
         '{ROW_BEAT, CMD_SMOOTH, 1'b1, CSR_PWM_TOP, 16'd0, 1'b1,
           rsp_payload_type'{1'b0, 1'b1, 2'd1, 4'b1001, 16'd0, 16'd65535, 1'b1, 1'b0}},
         '{ROW_BEAT, CMD_TICK, 1'b0, CSR_PWM_TOP, 16'd0, 1'b1,
           rsp_payload_type'{1'b0, 1'b1, 2'd1, 4'b1001, 16'd65535, 16'd0, 1'b1, 1'b0}},
         '{ROW_BEAT, CMD_TICK, 1'b1, CSR_PWM_TOP, 16'd0, 1'b1,
           rsp_payload_type'{1'b0, 1'b0, 2'd1, 4'b1001, 16'd65535, 16'd0, 1'b0, 1'b1}},
         '{ROW_BEAT, CMD_TICK, 1'b0, CSR_PWM_TOP, 16'd0, 1'b0, NO_WANT},
         // Top below the held ramp level: the B level must not wrap.
         '{ROW_CSR, CMD_TICK, 1'b0, CSR_PWM_TOP, 16'd2, 1'b0, NO_WANT},
         '{ROW_BEAT, CMD_TICK, 1'b0, CSR_PWM_TOP, 16'd0, 1'b1,
           rsp_payload_type'{1'b0, 1'b0, 2'd1, 4'b1001, 16'd65535, 16'd0, 1'b0, 1'b0}},
         '{ROW_CSR, CMD_TICK, 1'b0, CSR_MICROSTEPS, 16'd1024, 1'b0, NO_WANT},
         '{ROW_CSR, CMD_TICK, 1'b0, CSR_STEP_TIME, 16'd1, 1'b0, NO_WANT},
         '{ROW_BEAT, CMD_SMOOTH, 1'b1, CSR_PWM_TOP, 16'd0, 1'b1,
           rsp_payload_type'{1'b1, 1'b1, 2'd0, 4'b1010, 16'd2, 16'd0, 1'b1, 1'b0}},
         // Full step in the middle of a ramp shows top on both coils.
         '{ROW_BEAT, CMD_FULL, 1'b0, CSR_PWM_TOP, 16'd0, 1'b1,
           rsp_payload_type'{1'b1, 1'b1, 2'd1, 4'b1001, 16'd2, 16'd2, 1'b1, 1'b0}},
         '{ROW_BEAT, CMD_UNUSED, 1'b0, CSR_PWM_TOP, 16'd0, 1'b0, NO_WANT},
         '{ROW_BEAT, CMD_TICK, 1'b0, CSR_PWM_TOP, 16'd0, 1'b0, NO_WANT},
         '{ROW_BEAT, CMD_TICK, 1'b1, CSR_PWM_TOP, 16'd0, 1'b0, NO_WANT},
         '{ROW_BEAT, CMD_TICK, 1'b0, CSR_PWM_TOP, 16'd0, 1'b0, NO_WANT},
         '{ROW_BEAT, CMD_SMOOTH, 1'b0, CSR_PWM_TOP, 16'd0, 1'b0, NO_WANT}
      };

      steps_counted = 0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      for (int i = 0; i < PLAN_ROWS; i++) begin
         if (directed_plan[i].kind == ROW_CSR) begin
            drain();
            write_reg(directed_plan[i].idx, directed_plan[i].data);
            csr_we <= 1'b0;
         end else begin
            send_beat(directed_plan[i].cmd, directed_plan[i].dir, directed_plan[i].typed,
                      directed_plan[i].want);
         end
      end

      while (steps_counted < ITEM_TARGET) begin
         last = (steps_counted >= ITEM_TARGET - 80);
         drain();
         roll = $urandom_range(0, 9);
         if (last) begin
            // Slowest settings close the run; the ramp is left unfinished.
            top_v   = $urandom_range(0, 65535);
            mstep_v = $urandom_range(0, 1) ? 1024 : 2047;
            time_v  = $urandom_range(0, 1) ? 1000 : 1023;
         end else if (roll <= 3) begin
            top_v   = $urandom_range(0, 65535);
            mstep_v = $urandom_range(0, 40);
            time_v  = 0;
         end else if (roll <= 6) begin
            top_v   = $urandom_range(0, 60);
            mstep_v = $urandom_range(1000, 2047);
            time_v  = 1;
         end else if (roll <= 8) begin
            top_v   = $urandom_range(0, 65535);
            mstep_v = $urandom_range(0, 2047);
            time_v  = $urandom_range(0, 1023);
         end else begin
            top_v   = TOP_EDGES[$urandom_range(0, 2)];
            mstep_v = MSTEP_EDGES[$urandom_range(0, 3)];
            time_v  = TIME_EDGES[$urandom_range(0, 3)];
         end
         write_reg(CSR_PWM_TOP, CSR_DATA_BITS'(top_v));
         // Bits above the register width carry noise that must be dropped.
         data = CSR_DATA_BITS'($urandom_range(0, 65535));
         data[CFG_MSTEP_BITS-1:0] = CFG_MSTEP_BITS'(mstep_v);
         write_reg(CSR_MICROSTEPS, data);
         data = CSR_DATA_BITS'($urandom_range(0, 65535));
         data[CFG_TIME_BITS-1:0] = CFG_TIME_BITS'(time_v);
         write_reg(CSR_STEP_TIME, data);
         if ($urandom_range(0, 4) == 0)
            write_reg(CSR_UNUSED, CSR_DATA_BITS'($urandom_range(0, 65535)));
         csr_we <= 1'b0;

         calm = ($urandom_range(0, 3) == 0);
         len  = $urandom_range(20, 80);
         repeat (len) begin
            roll = $urandom_range(0, 99);
            dir  = 1'($urandom_range(0, 1));
            if (!st_busy) begin
               // Ramps too long to finish are only started in the closing phase.
               if (roll < 60)
                  cmd = (last || ramp_length() <= RAMP_TICK_CAP) ? CMD_SMOOTH : CMD_FULL;
               else if (roll < 85)
                  cmd = CMD_FULL;
               else if (roll < 93)
                  cmd = CMD_TICK;
               else
                  cmd = CMD_UNUSED;
            end else begin
               if (roll < 84)
                  cmd = CMD_TICK;
               else if (roll < 91)
                  cmd = CMD_FULL;
               else if (roll < 96)
                  cmd = CMD_SMOOTH;
               else
                  cmd = CMD_UNUSED;
            end
            send_beat(cmd, dir, 1'b0, NO_WANT);
            steps_counted++;
         end
      end

      calm = 1'b0;
      drain();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (fault_count == 0 && drive_due.size() == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

endmodule
